@@ hw/rtl/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, codes, tables and payload types of the UV sphere vertex
// generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int IDX_W        = 12;          // ring / column index
  localparam int STEP_W       = 13;          // step count registers
  localparam int RAD_W        = 16;          // radius, unsigned Q8.8
  localparam int MAX_STEPS    = 4096;
  localparam int PH_W         = 32;          // phase, 2^-32 turn
  localparam int DIV_W        = IDX_W + PH_W; // dividend / quotient bits
  localparam int TEX_W        = 28;          // texcoord quotient bits
  localparam int TEX_U_LSB    = 16;
  localparam int TEX_V_LSB    = 15;
  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CW           = 34;          // cordic datapath
  localparam int TRIG_FRAC    = 15;
  localparam int TRIG_W       = TRIG_FRAC + 3;
  localparam int RND_SH       = CORDIC_FRAC - TRIG_FRAC;
  localparam int SCL_SH       = TRIG_FRAC - 8;
  localparam int SCL_W        = RAD_W + TRIG_W + 1 - SCL_SH;
  localparam int PROD_W       = 2 * SCL_W;
  localparam int COMP_W       = 32;
  localparam int KIND_W       = 3;
  localparam int CFG_IDX_W    = 2;

  localparam logic [KIND_W-1:0] KIND_POS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TEX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BIN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NRM = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AROUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE   = 2'd2;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] CORDIC_HALF = CW'(64'd1 << (RND_SH - 1));

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } tex_t;

  typedef struct packed {
    logic [PH_W-1:0] theta;
    logic [PH_W-1:0] phi;
    tex_t            tex;
  } angle_t;

  typedef struct packed {
    trig_t sin_t;
    trig_t cos_t;
    trig_t sin_p;
    trig_t cos_p;
    tex_t  tex;
  } trig_set_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t pos;
    vec3_t tex;
    vec3_t tan;
    vec3_t bin;
    vec3_t nrm;
  } vertex_t;

  // atan(2^-k) in 2^-32 turn
  function automatic logic [PH_W-1:0] atan_turn(input int k);
    unique case (k)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      24: return 32'd41;
      25: return 32'd20;
      26: return 32'd10;
      27: return 32'd5;
      28: return 32'd3;
      29: return 32'd1;
      default: return '0;
    endcase
  endfunction

endpackage

@@ hw/rtl/uvs_if.sv @@
// ----------------------------------------------------------------------------
// uvs_in_if / uvs_out_if
// Valid/ready channels for vertex requests and result vectors.
// ----------------------------------------------------------------------------
interface uvs_in_if;
  import uvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] ring_index;
  logic [IDX_W-1:0] column_index;

  modport source (output valid, ring_index, column_index, input ready);
  modport sink   (input valid, ring_index, column_index, output ready);
endinterface

interface uvs_out_if;
  import uvs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        vector_kind;
  logic signed [COMP_W-1:0] comp_x;
  logic signed [COMP_W-1:0] comp_y;
  logic signed [COMP_W-1:0] comp_z;
  logic                     last_vector;

  modport source (output valid, vector_kind, comp_x, comp_y, comp_z, last_vector,
                  input ready);
  modport sink   (input valid, vector_kind, comp_x, comp_y, comp_z, last_vector,
                  output ready);
endinterface

@@ hw/rtl/uv_sphere_vertex_generator_unit.sv @@
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// UV sphere vertex generator: ring/column index in, position, texcoord,
// tangent, binormal and normal out as five transactions.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  in_i     | in  | valid/ready  | ring_index[11:0], column_index[11:0]
//  out_o    | out | valid/ready  | vector_kind[2:0], comp_x/y/z[31:0], last_vector
//  cfg_*    | in  | we only      | cfg_index_i[1:0], cfg_wdata_i[15:0]
//
//  Sustained rate is set by the single result channel, which carries five
//  transactions per vertex. 44 divider stages, 32 CORDIC stages, 4 math stages,
//  one output register. A new request can enter each cycle the pipe moves.
//  The pipe holds while a finished vertex waits on a stalled output; nothing to clear after reset.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  uvs_in_if.sink                        in_i,
  uvs_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [uvs_pkg::RAD_W-1:0]     cfg_wdata_i
);
  import uvs_pkg::*;

  logic [RAD_W-1:0]  radius_q;
  logic [STEP_W-1:0] around_q;
  logic [STEP_W-1:0] pole_q;
  logic [IDX_W-1:0]  dt;
  logic [IDX_W-1:0]  dp;

  logic      adv;
  logic      div_valid;
  angle_t    div_angle;
  logic      cor_valid;
  trig_set_t cor_trig;
  logic      math_valid;
  vertex_t   math_vtx;

  logic              ser_valid_q;
  logic [KIND_W-1:0] kind_q;
  vertex_t           vtx_q;
  logic              out_fire;
  logic              load;
  vec3_t             cur;

  // clamped step count minus one
  function automatic logic [IDX_W-1:0] steps_m1(input logic [STEP_W-1:0] n);
    logic [STEP_W-1:0] t;
    t = n - 1'b1;
    if (n < STEP_W'(2)) return IDX_W'(1);
    if (n > STEP_W'(MAX_STEPS)) return IDX_W'(MAX_STEPS - 1);
    return t[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(256);
      around_q <= STEP_W'(32);
      pole_q   <= STEP_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_wdata_i;
        CFG_AROUND: around_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_POLE:   pole_q   <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign dt = steps_m1(around_q);
  assign dp = steps_m1(pole_q);

  assign out_fire = ser_valid_q && out_o.ready;
  assign load     = !ser_valid_q || (out_fire && kind_q == KIND_NRM);
  assign adv      = !math_valid || load;
  assign in_i.ready = adv;

  uvs_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_i.valid),
    .ring_i   (in_i.ring_index),
    .column_i (in_i.column_index),
    .dt_i     (dt),
    .dp_i     (dp),
    .valid_o  (div_valid),
    .angle_o  (div_angle)
  );

  uvs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_valid),
    .angle_i (div_angle),
    .valid_o (cor_valid),
    .trig_o  (cor_trig)
  );

  uvs_vec_math u_math (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (cor_valid),
    .trig_i   (cor_trig),
    .radius_i (radius_q),
    .valid_o  (math_valid),
    .vtx_o    (math_vtx)
  );

  // result serializer: five transactions per vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      kind_q      <= KIND_POS;
    end else if (load) begin
      ser_valid_q <= math_valid;
      kind_q      <= KIND_POS;
    end else if (out_fire) begin
      kind_q <= kind_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && math_valid) vtx_q <= math_vtx;
  end

  always_comb begin
    case (kind_q)
      KIND_POS: cur = vtx_q.pos;
      KIND_TEX: cur = vtx_q.tex;
      KIND_TAN: cur = vtx_q.tan;
      KIND_BIN: cur = vtx_q.bin;
      default:  cur = vtx_q.nrm;
    endcase
  end

  assign out_o.valid       = ser_valid_q;
  assign out_o.vector_kind = kind_q;
  assign out_o.comp_x      = cur.x;
  assign out_o.comp_y      = cur.y;
  assign out_o.comp_z      = cur.z;
  assign out_o.last_vector = (kind_q == KIND_NRM);

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_q |-> (kind_q <= KIND_NRM))
    else $error("vector kind out of range");

  a_kind_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && kind_q != KIND_NRM) |=>
      (ser_valid_q && kind_q == $past(kind_q) + 3'd1))
    else $error("vector sequence broken");

  a_next_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && kind_q == KIND_NRM) |=>
      (ser_valid_q == $past(math_valid) && kind_q == KIND_POS))
    else $error("vertex handoff lost or invented");

endmodule

@@ hw/rtl/uvs_div_pipe.sv @@
// ----------------------------------------------------------------------------
// uvs_div_pipe
// Restoring divider, one quotient bit per stage, two lanes: column and ring
// index over their step counts minus one give the phases and the texture coordinates.
// ----------------------------------------------------------------------------
module uvs_div_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [uvs_pkg::IDX_W-1:0] ring_i,
  input  logic [uvs_pkg::IDX_W-1:0] column_i,
  input  logic [uvs_pkg::IDX_W-1:0] dt_i,
  input  logic [uvs_pkg::IDX_W-1:0] dp_i,
  output logic                      valid_o,
  output uvs_pkg::angle_t           angle_o
);
  import uvs_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] ring;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] rem_t;
    logic [IDX_W-1:0] rem_p;
    logic [DIV_W-1:0] quo_t;
    logic [DIV_W-1:0] quo_p;
  } div_st_t;

  logic [DIV_W-1:0] vld_q;
  div_st_t          st_q [DIV_W];
  div_st_t          st_d [DIV_W];

  // returns {quotient bit, new remainder}
  function automatic logic [IDX_W:0] div_step(input logic [IDX_W-1:0] rem,
                                               input logic nb,
                                               input logic [IDX_W-1:0] d);
    logic [IDX_W:0] trial;
    logic [IDX_W:0] diff;
    trial = {rem, nb};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) return {1'b1, diff[IDX_W-1:0]};
    return {1'b0, trial[IDX_W-1:0]};
  endfunction

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    div_st_t        prv;
    logic [DIV_W-1:0] num_t;
    logic [DIV_W-1:0] num_p;
    logic [IDX_W:0] rt;
    logic [IDX_W:0] rp;

    if (s == 0) begin : g_first
      assign prv = '{ring: ring_i, col: column_i, rem_t: '0, rem_p: '0,
                     quo_t: '0, quo_p: '0};
    end else begin : g_next
      assign prv = st_q[s-1];
    end

    // column << 32 and ring << 31
    assign num_t = {prv.col, {(DIV_W-IDX_W){1'b0}}};
    assign num_p = {1'b0, prv.ring, {(DIV_W-IDX_W-1){1'b0}}};
    assign rt    = div_step(prv.rem_t, num_t[DIV_W-1-s], dt_i);
    assign rp    = div_step(prv.rem_p, num_p[DIV_W-1-s], dp_i);

    assign st_d[s] = '{ring:  prv.ring,
                       col:   prv.col,
                       rem_t: rt[IDX_W-1:0],
                       rem_p: rp[IDX_W-1:0],
                       quo_t: {prv.quo_t[DIV_W-2:0], rt[IDX_W]},
                       quo_p: {prv.quo_p[DIV_W-2:0], rp[IDX_W]}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < DIV_W; s++) st_q[s] <= st_d[s];
    end
  end

  assign valid_o       = vld_q[DIV_W-1];
  assign angle_o.theta = st_q[DIV_W-1].quo_t[PH_W-1:0];
  assign angle_o.phi   = st_q[DIV_W-1].quo_p[PH_W-1:0];
  assign angle_o.tex.u = st_q[DIV_W-1].quo_t[TEX_U_LSB+TEX_W-1:TEX_U_LSB];
  assign angle_o.tex.v = st_q[DIV_W-1].quo_p[TEX_V_LSB+TEX_W-1:TEX_V_LSB];

endmodule

@@ hw/rtl/uvs_cordic.sv @@
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation CORDIC, one iteration per stage, two lanes (theta, phi).
// Quadrant fold in front, rounding to Q3.15 at the end.
// ----------------------------------------------------------------------------
module uvs_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  uvs_pkg::angle_t    angle_i,
  output logic               valid_o,
  output uvs_pkg::trig_set_t trig_o
);
  import uvs_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } lane_t;

  typedef struct packed {
    lane_t lt;
    lane_t lp;
    tex_t  tex;
  } cst_t;

  localparam int NST = CORDIC_ITERS + 1;

  logic [NST:0] vld_q;
  cst_t         st_q [NST];
  cst_t         st_d [NST];
  trig_set_t    out_d;
  trig_set_t    out_q;

  // second and third quadrant: rotate by half a turn, negate at the end
  function automatic lane_t fold(input logic [PH_W-1:0] ph);
    lane_t           l;
    logic [PH_W-1:0] p;
    l.flip = ph[PH_W-1] ^ ph[PH_W-2];
    p      = l.flip ? {~ph[PH_W-1], ph[PH_W-2:0]} : ph;
    l.x    = CORDIC_GAIN;
    l.y    = '0;
    l.z    = {{(CW-PH_W){p[PH_W-1]}}, p};
    return l;
  endfunction

  function automatic lane_t rotate(input lane_t l, input int k);
    lane_t                r;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    x  = l.x;
    y  = l.y;
    z  = l.z;
    xs = x >>> k;
    ys = y >>> k;
    at = $signed({{(CW-PH_W){1'b0}}, atan_turn(k)});
    r.flip = l.flip;
    if (z >= 0) begin
      r.x = x - ys;
      r.y = y + xs;
      r.z = z - at;
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.z = z + at;
    end
    return r;
  endfunction

  function automatic trig_t to_trig(input logic signed [CW-1:0] v, input logic flip);
    logic signed [CW-1:0] r;
    r = (v + CORDIC_HALF) >>> RND_SH;
    if (flip) r = -r;
    return r[TRIG_W-1:0];
  endfunction

  assign st_d[0] = '{lt: fold(angle_i.theta), lp: fold(angle_i.phi), tex: angle_i.tex};

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
    assign st_d[k+1] = '{lt: rotate(st_q[k].lt, k), lp: rotate(st_q[k].lp, k),
                         tex: st_q[k].tex};
  end

  always_comb begin
    out_d.sin_t = to_trig(st_q[NST-1].lt.y, st_q[NST-1].lt.flip);
    out_d.cos_t = to_trig(st_q[NST-1].lt.x, st_q[NST-1].lt.flip);
    out_d.sin_p = to_trig(st_q[NST-1].lp.y, st_q[NST-1].lp.flip);
    out_d.cos_p = to_trig(st_q[NST-1].lp.x, st_q[NST-1].lp.flip);
    out_d.tex   = st_q[NST-1].tex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < NST; s++) st_q[s] <= st_d[s];
      out_q <= out_d;
    end
  end

  assign valid_o = vld_q[NST];
  assign trig_o  = out_q;

endmodule

@@ hw/rtl/uvs_vec_math.sv @@
// ----------------------------------------------------------------------------
// uvs_vec_math
// Four stages: trig products, radius scaling, cross-product multiplies,
// normal rounding and saturation. Assembles the five vectors of a vertex.
// ----------------------------------------------------------------------------
module uvs_vec_math (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  uvs_pkg::trig_set_t        trig_i,
  input  logic [uvs_pkg::RAD_W-1:0] radius_i,
  output logic                      valid_o,
  output uvs_pkg::vertex_t          vtx_o
);
  import uvs_pkg::*;

  typedef logic signed [SCL_W-1:0]  scl_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    trig_t ss;
    trig_t cs;
    trig_t sc;
    trig_t cc;
    trig_t sin_t;
    trig_t cos_t;
    trig_t sin_p;
    trig_t cos_p;
    tex_t  tex;
  } m1_t;

  typedef struct packed {
    scl_t px;
    scl_t py;
    scl_t pz;
    scl_t tx;
    scl_t tz;
    scl_t bx;
    scl_t by;
    scl_t bz;
    tex_t tex;
  } m2_t;

  typedef struct packed {
    scl_t  px;
    scl_t  py;
    scl_t  pz;
    scl_t  tx;
    scl_t  tz;
    scl_t  bx;
    scl_t  by;
    scl_t  bz;
    prod_t zy;
    prod_t zx;
    prod_t xz;
    prod_t xy;
    tex_t  tex;
  } m3_t;

  logic [3:0] vld_q;
  m1_t        m1_d, m1_q;
  m2_t        m2_d, m2_q;
  m3_t        m3_d, m3_q;
  vertex_t    m4_d, m4_q;

  function automatic trig_t tmul(input trig_t a, input trig_t b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    p = p + ({{(2*TRIG_W-1){1'b0}}, 1'b1} << (TRIG_FRAC - 1));
    p = p >>> TRIG_FRAC;
    return p[TRIG_W-1:0];
  endfunction

  function automatic scl_t scale_r(input logic [RAD_W-1:0] r, input trig_t t);
    logic signed [RAD_W+TRIG_W:0] p;
    p = $signed({1'b0, r}) * t;
    p = p + ({{(RAD_W+TRIG_W){1'b0}}, 1'b1} << (SCL_SH - 1));
    p = p >>> SCL_SH;
    return p[SCL_W-1:0];
  endfunction

  function automatic logic signed [COMP_W-1:0] round_sat(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] r;
    r = v + ({{PROD_W{1'b0}}, 1'b1} << 15);
    r = r >>> 16;
    if (r > $signed(PROD_W'(2147483647))) return 32'sh7fffffff;
    if (r < -$signed((PROD_W+1)'(64'd2147483648))) return 32'sh80000000;
    return r[COMP_W-1:0];
  endfunction

  always_comb begin
    m1_d.ss    = tmul(trig_i.sin_t, trig_i.sin_p);
    m1_d.cs    = tmul(trig_i.cos_t, trig_i.sin_p);
    m1_d.sc    = tmul(trig_i.sin_t, trig_i.cos_p);
    m1_d.cc    = tmul(trig_i.cos_t, trig_i.cos_p);
    m1_d.sin_t = trig_i.sin_t;
    m1_d.cos_t = trig_i.cos_t;
    m1_d.sin_p = trig_i.sin_p;
    m1_d.cos_p = trig_i.cos_p;
    m1_d.tex   = trig_i.tex;
  end

  always_comb begin
    m2_d.px  = scale_r(radius_i, m1_q.ss);
    m2_d.py  = -scale_r(radius_i, m1_q.cos_p);
    m2_d.pz  = scale_r(radius_i, m1_q.cs);
    m2_d.tx  = scale_r(radius_i, m1_q.cos_t);
    m2_d.tz  = -scale_r(radius_i, m1_q.sin_t);
    m2_d.bx  = scale_r(radius_i, m1_q.sc);
    m2_d.by  = scale_r(radius_i, m1_q.sin_p);
    m2_d.bz  = scale_r(radius_i, m1_q.cc);
    m2_d.tex = m1_q.tex;
  end

  // tangent y is zero, so only four products remain
  always_comb begin
    m3_d.px  = m2_q.px;
    m3_d.py  = m2_q.py;
    m3_d.pz  = m2_q.pz;
    m3_d.tx  = m2_q.tx;
    m3_d.tz  = m2_q.tz;
    m3_d.bx  = m2_q.bx;
    m3_d.by  = m2_q.by;
    m3_d.bz  = m2_q.bz;
    m3_d.zy  = m2_q.tz * m2_q.by;
    m3_d.zx  = m2_q.tz * m2_q.bx;
    m3_d.xz  = m2_q.tx * m2_q.bz;
    m3_d.xy  = m2_q.tx * m2_q.by;
    m3_d.tex = m2_q.tex;
  end

  always_comb begin
    logic signed [PROD_W:0] dx;
    logic signed [PROD_W:0] dy;
    logic signed [PROD_W:0] dz;
    dx = -m3_q.zy;
    dy = m3_q.zx - m3_q.xz;
    dz = m3_q.xy;
    m4_d.pos.x = COMP_W'(m3_q.px);
    m4_d.pos.y = COMP_W'(m3_q.py);
    m4_d.pos.z = COMP_W'(m3_q.pz);
    m4_d.tex.x = $signed(COMP_W'(m3_q.tex.u));
    m4_d.tex.y = $signed(COMP_W'(m3_q.tex.v));
    m4_d.tex.z = '0;
    m4_d.tan.x = COMP_W'(m3_q.tx);
    m4_d.tan.y = '0;
    m4_d.tan.z = COMP_W'(m3_q.tz);
    m4_d.bin.x = COMP_W'(m3_q.bx);
    m4_d.bin.y = COMP_W'(m3_q.by);
    m4_d.bin.z = COMP_W'(m3_q.bz);
    m4_d.nrm.x = round_sat(dx);
    m4_d.nrm.y = round_sat(dy);
    m4_d.nrm.z = round_sat(dz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      m3_q <= m3_d;
      m4_q <= m4_d;
    end
  end

  assign valid_o = vld_q[3];
  assign vtx_o   = m4_q;

endmodule
